// ===== design/membrane_wave_fdtd_step_unit_macros.svh =====
// assertion macros for the membrane wave step unit
`ifndef MEMBRANE_WAVE_FDTD_STEP_UNIT_MACROS_SVH
`define MEMBRANE_WAVE_FDTD_STEP_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define MWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("membrane step unit check failed");
// checked during reset as well
`define MWS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("membrane step unit reset check failed");
`else
`define MWS_ASSERT(lbl, prop)
`define MWS_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== design/mws_pkg.sv =====
// shared types, codes and tables of the membrane wave step unit
package mws_pkg;

  localparam int MWS_GRID_SIDE     = 64;
  localparam int MWS_IMPULSE_REACH = 5;

  // request codes
  localparam logic [1:0] REQ_STEP    = 2'd0;
  localparam logic [1:0] REQ_IMPULSE = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_RADIUS  = 2'd0;
  localparam logic [1:0] CFG_TENSION = 2'd1;
  localparam logic [1:0] CFG_DAMPING = 2'd2;

  localparam logic [15:0] RADIUS_RST  = 16'd8064;
  localparam logic [23:0] TENSION_RST = 24'd65536;
  localparam logic [15:0] DAMPING_RST = 16'd66;

  typedef logic [1:0]         req_type_t;
  typedef logic signed [23:0] height_t;
  typedef logic [23:0]        cfg_data_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RSQ, ST_RSQ_CAP, ST_DTSQ, ST_TEN, ST_COEF,
    ST_CELL, ST_ZERO, ST_COPY, ST_IMP, ST_READ, ST_DONE
  } state_e;

  // gaussian gain exp(-d2/2.5), unsigned Q1.16
  function automatic logic [16:0] gauss_gain(input logic [4:0] idx);
    logic [16:0] g;
    case (idx)
      5'd0:  g = 17'd65536;
      5'd1:  g = 17'd43930;
      5'd2:  g = 17'd29447;
      5'd3:  g = 17'd19739;
      5'd4:  g = 17'd13231;
      5'd5:  g = 17'd8869;
      5'd6:  g = 17'd5945;
      5'd7:  g = 17'd3985;
      5'd8:  g = 17'd2671;
      5'd9:  g = 17'd1791;
      5'd10: g = 17'd1200;
      5'd11: g = 17'd805;
      5'd12: g = 17'd539;
      5'd13: g = 17'd362;
      5'd14: g = 17'd242;
      5'd15: g = 17'd162;
      5'd16: g = 17'd109;
      5'd17: g = 17'd73;
      5'd18: g = 17'd49;
      5'd19: g = 17'd33;
      5'd20: g = 17'd22;
      5'd21: g = 17'd15;
      5'd22: g = 17'd10;
      5'd23: g = 17'd7;
      5'd24: g = 17'd4;
      5'd25: g = 17'd3;
      default: g = 17'd0;
    endcase
    return g;
  endfunction

endpackage

// ===== design/mws_if.sv =====
// handshake channels of the membrane wave step unit

// request channel
interface mws_req_if import mws_pkg::*; ();
  logic      valid;
  logic      ready;
  req_type_t req_type;
  logic [15:0] time_step;
  logic [5:0]  grid_x;
  logic [5:0]  grid_y;
  height_t   strike_strength;
  modport source (output valid, req_type, time_step, grid_x, grid_y, strike_strength,
                  input ready);
  modport sink (input valid, req_type, time_step, grid_x, grid_y, strike_strength,
                output ready);
endinterface

// response channel
interface mws_rsp_if import mws_pkg::*; ();
  logic      valid;
  logic      ready;
  height_t   height_value;
  req_type_t done_type;
  modport source (output valid, height_value, done_type, input ready);
  modport sink (input valid, height_value, done_type, output ready);
endinterface

// configuration write channel
interface mws_cfg_if import mws_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  cfg_data_t  wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== design/membrane_wave_fdtd_step_unit.sv =====
// membrane wave step unit: two height grids, one shared multiplier under a sequencer
//
//   channel   dir   payload                                              word when
//   cfg_i     in    reg_index, wdata                                     valid & ready
//   req_i     in    req_type, time_step, grid_x, grid_y, strike_strength valid & ready
//   rsp_o     out   height_value, done_type                              valid & ready
//
// reset runs a zeroing pass over both grid rams before req_i.ready.
// time step: interior cells inside the circle are updated from four neighbour reads,
//   other cells are written back or zeroed, then a pass zeroes outside cells; the
//   first step after start is a copy. the single ram read port serializes the reads.
// impulse: patch of (2*IMPULSE_REACH+1)^2 points; read: one cell; clear: both grids.
// one word at a time; a result left in the output register stalls the next in ST_DONE.
`include "membrane_wave_fdtd_step_unit_macros.svh"
module membrane_wave_fdtd_step_unit import mws_pkg::*; #(
  parameter int GRID_SIDE     = MWS_GRID_SIDE,
  parameter int IMPULSE_REACH = MWS_IMPULSE_REACH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mws_cfg_if.sink   cfg_i,
  mws_req_if.sink   req_i,
  mws_rsp_if.source rsp_o
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int IW    = ((CW > 6) ? CW : 6) + 2;
  localparam int PW    = $clog2(IMPULSE_REACH + 1) + 1;
  localparam int D2W   = $clog2(2 * IMPULSE_REACH * IMPULSE_REACH + 1);
  localparam int SW    = 2 * IW + 21;

  // circle test, exact
  function automatic logic circ(input logic signed [IW-1:0] xx, input logic signed [IW-1:0] yy,
                                input logic [33:0] r4);
    logic signed [IW+1:0]   dx;
    logic signed [IW+1:0]   dy;
    logic signed [2*IW+3:0] qx;
    logic signed [2*IW+3:0] qy;
    logic [2*IW+4:0]        sm;
    dx = {xx[IW-1], xx, 1'b0} - (IW+2)'(GRID_SIDE - 1);
    dy = {yy[IW-1], yy, 1'b0} - (IW+2)'(GRID_SIDE - 1);
    qx = dx * dx;
    qy = dy * dy;
    sm = {1'b0, qx} + {1'b0, qy};
    return {sm, 16'b0} <= SW'(r4);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic signed [IW-1:0] xx,
                                           input logic signed [IW-1:0] yy);
    return AW'(int'($unsigned(yy)) * GRID_SIDE + int'($unsigned(xx)));
  endfunction

  function automatic height_t sat24(input logic signed [27:0] v);
    height_t r;
    if (v > 28'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] abs28(input logic signed [27:0] v);
    logic [27:0] m;
    m = v[27] ? 28'(-v) : 28'(v);
    return 32'(m);
  endfunction

  state_e state_q, state_d;
  logic   cur_q, started_q, rst_clr_q;
  logic [CW-1:0] x_q, y_q;
  logic [3:0]    ph_q;

  req_type_t   rtype_q;
  logic [15:0] dt_q;
  logic [5:0]  gx_q, gy_q;
  height_t     str_q;

  logic [15:0] radius_q;
  logic [23:0] tension_q;
  logic [15:0] damp_q;
  logic [33:0] r4_q;
  logic [30:0] coef_q;

  height_t                u_q, pv_q, res_q;
  logic signed [27:0]     acc_q, v_q;
  logic                   sgn_q;
  logic signed [PW-1:0]   pdx_q, pdy_q;
  logic signed [IW-1:0]   ix_q, iy_q;
  logic [D2W-1:0]         d2_q;

  logic      out_valid_q;
  height_t   out_h_q;
  req_type_t out_t_q;

  // grid ram ports, by role
  logic          h_we, p_we;
  logic [AW-1:0] h_raddr, p_raddr, h_waddr, p_waddr;
  height_t       h_wd, p_wd;
  logic [23:0]   rd0, rd1;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;

  // derived values
  logic signed [IW-1:0] cell_x, cell_y, gxe, gye;
  logic [AW-1:0] cell_addr, imp_addr, rd_addr;
  logic          cell_in, interior, last_cell, imp_ok, imp_off, rd_off, patch_last;
  logic          req_acc, cell_end, imp_end;
  height_t       hrd, prd, new_cell, imp_new;
  logic [63:0]   pr32, pr16;
  logic signed [27:0] lap_r, dmp_r, imp_add, imp_sum, v_new;
  logic [16:0]   keep;
  logic signed [2*PW-1:0] sqx, sqy;
  logic [24:0]   str_ext, str_mag;

  assign cell_x    = $signed({{(IW-CW){1'b0}}, x_q});
  assign cell_y    = $signed({{(IW-CW){1'b0}}, y_q});
  assign gxe       = $signed({{(IW-6){1'b0}}, gx_q});
  assign gye       = $signed({{(IW-6){1'b0}}, gy_q});
  assign cell_addr = addr_of(cell_x, cell_y);
  assign imp_addr  = addr_of(ix_q, iy_q);
  assign rd_addr   = addr_of(gxe, gye);
  assign cell_in   = circ(cell_x, cell_y, r4_q);
  assign interior  = (x_q != '0) && (x_q != CW'(GRID_SIDE - 1))
                  && (y_q != '0) && (y_q != CW'(GRID_SIDE - 1));
  assign last_cell = (x_q == CW'(GRID_SIDE - 1)) && (y_q == CW'(GRID_SIDE - 1));
  assign imp_off   = (int'(gx_q) >= GRID_SIDE) || (int'(gy_q) >= GRID_SIDE);
  assign rd_off    = imp_off;
  assign imp_ok    = !ix_q[IW-1] && !iy_q[IW-1]
                  && (int'($unsigned(ix_q)) < GRID_SIDE) && (int'($unsigned(iy_q)) < GRID_SIDE)
                  && circ(ix_q, iy_q, r4_q)
                  && (int'(d2_q) <= IMPULSE_REACH * IMPULSE_REACH) && (int'(d2_q) <= 25);
  assign patch_last = (pdx_q == PW'(IMPULSE_REACH)) && (pdy_q == PW'(IMPULSE_REACH));
  assign req_acc   = req_i.valid && req_i.ready;
  assign cell_end  = (state_q == ST_CELL)
                  && (((ph_q == 4'd1) && !(interior && cell_in)) || (ph_q == 4'd9));
  assign imp_end   = (state_q == ST_IMP)
                  && (((ph_q == 4'd1) && !imp_ok) || (ph_q == 4'd2));

  assign hrd = cur_q ? $signed(rd1) : $signed(rd0);
  assign prd = cur_q ? $signed(rd0) : $signed(rd1);

  // rounding of the shared product, ties away from zero
  assign pr32     = mul_p + 64'd2147483648;
  assign pr16     = mul_p + 64'd32768;
  assign lap_r    = sgn_q ? -$signed({3'b0, pr32[56:32]}) : $signed({3'b0, pr32[56:32]});
  assign dmp_r    = sgn_q ? -$signed({1'b0, pr16[42:16]}) : $signed({1'b0, pr16[42:16]});
  assign imp_add  = sgn_q ? -$signed({4'b0, pr16[39:16]}) : $signed({4'b0, pr16[39:16]});
  assign new_cell = sat24(dmp_r);
  assign imp_sum  = 28'(hrd) + imp_add;
  assign imp_new  = sat24(imp_sum);
  assign v_new    = 28'(u_q) + 28'(u_q) - 28'(pv_q) + lap_r;
  assign keep     = 17'h10000 - {1'b0, damp_q};
  assign sqx      = pdx_q * pdx_q;
  assign sqy      = pdy_q * pdy_q;
  assign str_ext  = {str_q[23], str_q};
  assign str_mag  = str_q[23] ? 25'(-str_ext) : str_ext;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (last_cell) state_d = rst_clr_q ? ST_IDLE : ST_DONE;
      ST_IDLE: begin
        if (req_acc) begin
          case (req_i.req_type)
            REQ_STEP:    state_d = started_q ? ST_RSQ : ST_COPY;
            REQ_IMPULSE: state_d = ST_RSQ;
            REQ_READ:    state_d = ST_READ;
            default:     state_d = ST_CLEAR;
          endcase
        end
      end
      ST_RSQ:     state_d = ST_RSQ_CAP;
      ST_RSQ_CAP: begin
        if (rtype_q == REQ_STEP) begin
          state_d = ST_DTSQ;
        end else begin
          state_d = imp_off ? ST_DONE : ST_IMP;
        end
      end
      ST_DTSQ: state_d = ST_TEN;
      ST_TEN:  state_d = ST_COEF;
      ST_COEF: state_d = ST_CELL;
      ST_CELL: if (cell_end && last_cell) state_d = ST_ZERO;
      ST_ZERO: if (last_cell) state_d = ST_DONE;
      ST_COPY: if ((ph_q == 4'd1) && last_cell) state_d = ST_DONE;
      ST_IMP:  if (imp_end && patch_last) state_d = ST_DONE;
      ST_READ: if ((ph_q == 4'd1) || rd_off) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || rsp_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ram and multiplier controls
  always_comb begin
    h_we = 1'b0; p_we = 1'b0;
    h_raddr = cell_addr; p_raddr = cell_addr;
    h_waddr = cell_addr; p_waddr = cell_addr;
    h_wd = '0; p_wd = '0;
    mul_a = '0; mul_b = '0;
    case (state_q)
      ST_CLEAR: begin
        h_we = 1'b1;
        p_we = 1'b1;
      end
      ST_RSQ: begin
        mul_a = 32'(radius_q);
        mul_b = 32'(radius_q);
      end
      ST_DTSQ: begin
        mul_a = 32'(dt_q);
        mul_b = 32'(dt_q);
      end
      ST_TEN: begin
        mul_a = 32'(tension_q);
        mul_b = mul_p[31:0];
      end
      ST_CELL: begin
        case (ph_q)
          4'd1: begin
            if (!(interior && cell_in)) begin
              p_we = 1'b1;
              p_wd = cell_in ? hrd : '0;
            end else begin
              h_raddr = cell_addr - AW'(1);
            end
          end
          4'd2: h_raddr = cell_addr + AW'(1);
          4'd3: h_raddr = cell_addr - AW'(GRID_SIDE);
          4'd4: h_raddr = cell_addr + AW'(GRID_SIDE);
          4'd6: begin
            mul_a = abs28(acc_q);
            mul_b = 32'(coef_q);
          end
          4'd8: begin
            mul_a = abs28(v_q);
            mul_b = 32'(keep);
          end
          4'd9: begin
            p_we = 1'b1;
            p_wd = new_cell;
          end
          default: ;
        endcase
      end
      ST_ZERO: h_we = !cell_in;
      ST_COPY: begin
        if (ph_q == 4'd1) begin
          p_we = 1'b1;
          p_wd = hrd;
        end
      end
      ST_IMP: begin
        h_raddr = imp_addr;
        h_waddr = imp_addr;
        if (ph_q == 4'd1) begin
          mul_a = 32'(str_mag);
          mul_b = 32'(gauss_gain(5'(d2_q)));
        end else if (ph_q == 4'd2) begin
          h_we = 1'b1;
          h_wd = imp_new;
        end
      end
      ST_READ: h_raddr = rd_addr;
      default: ;
    endcase
  end

  // grid rams; roles swap after the zeroing pass of each step
  mws_ram #(.WIDTH(24), .DEPTH(CELLS)) u_grid0 (
    .clk_i   (clk_i),
    .we_i    (cur_q ? p_we : h_we),
    .waddr_i (cur_q ? p_waddr : h_waddr),
    .wdata_i (cur_q ? p_wd : h_wd),
    .raddr_i (cur_q ? p_raddr : h_raddr),
    .rdata_o (rd0)
  );

  mws_ram #(.WIDTH(24), .DEPTH(CELLS)) u_grid1 (
    .clk_i   (clk_i),
    .we_i    (cur_q ? h_we : p_we),
    .waddr_i (cur_q ? h_waddr : p_waddr),
    .wdata_i (cur_q ? h_wd : p_wd),
    .raddr_i (cur_q ? h_raddr : p_raddr),
    .rdata_o (rd1)
  );

  mws_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // sequencer, counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_q       <= 1'b0;
      started_q   <= 1'b0;
      rst_clr_q   <= 1'b1;
      x_q         <= '0;
      y_q         <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // cell walk
      if ((state_q == ST_CLEAR) || (state_q == ST_ZERO) || cell_end
          || ((state_q == ST_COPY) && (ph_q == 4'd1))) begin
        if (x_q == CW'(GRID_SIDE - 1)) begin
          x_q <= '0;
          y_q <= (y_q == CW'(GRID_SIDE - 1)) ? '0 : y_q + CW'(1);
        end else begin
          x_q <= x_q + CW'(1);
        end
      end
      // phase within one cell or one patch point
      if (cell_end || imp_end || ((state_q == ST_COPY) && (ph_q == 4'd1))) begin
        ph_q <= '0;
      end else if ((state_q == ST_CELL) || (state_q == ST_COPY)
                   || (state_q == ST_IMP) || (state_q == ST_READ)) begin
        ph_q <= ph_q + 4'd1;
      end else begin
        ph_q <= '0;
      end
      if ((state_q == ST_CLEAR) && last_cell) rst_clr_q <= 1'b0;
      if ((state_q == ST_ZERO) && last_cell) begin
        cur_q     <= ~cur_q;
        started_q <= (dt_q != '0);
      end
      if ((state_q == ST_COPY) && (ph_q == 4'd1) && last_cell) started_q <= (dt_q != '0);
      // output register
      if ((state_q == ST_DONE) && (!out_valid_q || rsp_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      tension_q <= TENSION_RST;
      damp_q    <= DAMPING_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.reg_index)
        CFG_RADIUS:  radius_q  <= cfg_i.wdata[15:0];
        CFG_TENSION: tension_q <= cfg_i.wdata;
        CFG_DAMPING: damp_q    <= cfg_i.wdata[15:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      rtype_q <= req_i.req_type;
      dt_q    <= req_i.time_step;
      gx_q    <= req_i.grid_x;
      gy_q    <= req_i.grid_y;
      str_q   <= req_i.strike_strength;
      res_q   <= '0;
    end
    if (state_q == ST_RSQ_CAP) begin
      r4_q  <= {mul_p[31:0], 2'b00};
      pdx_q <= PW'(-IMPULSE_REACH);
      pdy_q <= PW'(-IMPULSE_REACH);
    end
    if (state_q == ST_COEF) begin
      coef_q <= (mul_p > (64'd1 << 46)) ? 31'h4000_0000 : mul_p[46:16];
    end
    if (state_q == ST_CELL) begin
      case (ph_q)
        4'd1: begin
          u_q   <= hrd;
          pv_q  <= prd;
          acc_q <= -(28'(hrd) <<< 2);
        end
        4'd2, 4'd3, 4'd4, 4'd5: acc_q <= acc_q + 28'(hrd);
        4'd6: sgn_q <= acc_q[27];
        4'd7: v_q <= v_new;
        4'd8: sgn_q <= v_q[27];
        default: ;
      endcase
    end
    if (state_q == ST_IMP) begin
      if (ph_q == 4'd0) begin
        ix_q <= gxe + IW'(pdx_q);
        iy_q <= gye + IW'(pdy_q);
        d2_q <= D2W'(sqx + sqy);
      end
      if (ph_q == 4'd1) sgn_q <= str_q[23];
      if (imp_end) begin
        if (pdx_q == PW'(IMPULSE_REACH)) begin
          pdx_q <= PW'(-IMPULSE_REACH);
          pdy_q <= pdy_q + PW'(1);
        end else begin
          pdx_q <= pdx_q + PW'(1);
        end
      end
    end
    if ((state_q == ST_READ) && (ph_q == 4'd1)) res_q <= hrd;
    if ((state_q == ST_DONE) && (!out_valid_q || rsp_o.ready)) begin
      out_h_q <= res_q;
      out_t_q <= rtype_q;
    end
  end

  assign cfg_i.ready        = 1'b1;
  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.height_value = out_h_q;
  assign rsp_o.done_type    = out_t_q;

  // checks
  `MWS_ASSERT_RST(a_reset_blocks_input, !rst_ni |=> !req_i.ready)
  `MWS_ASSERT(a_result_from_done, $rose(rsp_o.valid) |-> $past(state_q == ST_DONE))
  `MWS_ASSERT(a_swap_after_zero, cur_q != $past(cur_q) |-> $past(state_q == ST_ZERO))
  `MWS_ASSERT(a_idle_no_write, state_q == ST_IDLE |-> !(h_we || p_we))

endmodule

// ===== design/mws_ram.sv =====
// generic single write, single read ram with registered read
module mws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/mws_mul.sv =====
// shared 32x32 unsigned multiplier with registered product
module mws_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  // product register
  always_ff @(posedge clk_i) begin
    p_o <= 64'(a_i) * 64'(b_i);
  end

endmodule
